// ===== rtl/mde_pkg.sv =====
`default_nettype none

package mde_pkg;

   typedef enum logic [5:0] {
      OP_SPECIAL = 6'h00,
      OP_J       = 6'h02,
      OP_JAL     = 6'h03,
      OP_BEQ     = 6'h04,
      OP_BNE     = 6'h05,
      OP_ADDI    = 6'h08,
      OP_ADDIU   = 6'h09,
      OP_SLTI    = 6'h0a,
      OP_SLTIU   = 6'h0b,
      OP_ANDI    = 6'h0c,
      OP_ORI     = 6'h0d,
      OP_LUI     = 6'h0f,
      OP_LW      = 6'h23,
      OP_LBU     = 6'h24,
      OP_LHU     = 6'h25,
      OP_SB      = 6'h28,
      OP_SH      = 6'h29,
      OP_SW      = 6'h2b,
      OP_LL      = 6'h30,
      OP_SC      = 6'h38
   } opcode_type;

   typedef enum logic [5:0] {
      FN_SLL  = 6'h00,
      FN_SRL  = 6'h02,
      FN_JR   = 6'h08,
      FN_ADD  = 6'h20,
      FN_ADDU = 6'h21,
      FN_SUB  = 6'h22,
      FN_SUBU = 6'h23,
      FN_AND  = 6'h24,
      FN_OR   = 6'h25,
      FN_NOR  = 6'h27,
      FN_SLT  = 6'h2a,
      FN_SLTU = 6'h2b
   } funct_type;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic [4:0] LINK_REG = 5'd31;

   typedef struct packed {
      logic [31:0] result;
      logic [4:0]  dest_reg;
      logic        reg_write;
      logic        mem_load;
      logic        mem_store;
      logic [1:0]  access_size;
      logic [31:0] store_data;
      logic [31:0] next_pc;
      logic        redirect;
      logic        overflow;
      logic        invalid;
   } exec_result_type;

endpackage

`default_nettype wire

// ===== rtl/mips_decode_execute.sv =====
// Path: a taken request is captured in the input register, then passes through decode and ALU into the result register,
// which drives the response; a stall on rsp_tready can hold a request in either register.
// Throughput: one instruction per cycle while rsp_tready does not stall; decode and ALU sit in one combinational stage.
// Either register advances whenever the stage after it is empty or being drained.
// Reset: synchronous, active high; clears both valid flags, payload registers are not reset.
`default_nettype none

module mips_decode_execute (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [31:0] instruction, [63:32] pc, [95:64] rs_value, [127:96] rt_value
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] result, [36:32] dest_reg, [37] reg_write, [38] mem_load, [39] mem_store,
   // [41:40] access_size, [73:42] store_data, [105:74] next_pc, [106] redirect,
   // [107] overflow, [108] invalid, [111:109] zero
   output logic [111:0]      rsp_tdata
);

   logic                      req_valid_ff;
   logic                      req_valid_in;
   logic [127:0]              req_data_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   mde_pkg::exec_result_type  rsp_ff;
   mde_pkg::exec_result_type  exec_out;
   logic                      rsp_advance;
   logic                      req_advance;

   // advance the result register when it is empty or its contents are taken
   assign rsp_advance  = !rsp_valid_ff || rsp_tready;
   assign req_advance  = !req_valid_ff || rsp_advance;
   assign req_tready   = req_advance;
   assign req_valid_in = req_advance ? req_tvalid : req_valid_ff;
   assign rsp_valid_in = rsp_advance ? req_valid_ff : rsp_valid_ff;

   mde_exec u_exec (
      .instruction (req_data_ff[31:0]),
      .pc          (req_data_ff[63:32]),
      .rs_value    (req_data_ff[95:64]),
      .rt_value    (req_data_ff[127:96]),
      .exec_out    (exec_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_advance && req_tvalid) begin
         req_data_ff <= req_tdata;
      end
      if (rsp_advance && req_valid_ff) begin
         rsp_ff <= exec_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.invalid, rsp_ff.overflow, rsp_ff.redirect,
                        rsp_ff.next_pc, rsp_ff.store_data, rsp_ff.access_size,
                        rsp_ff.mem_store, rsp_ff.mem_load, rsp_ff.reg_write,
                        rsp_ff.dest_reg, rsp_ff.result};

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_advance |=> rsp_tvalid)
      else $error("held request did not reach the result register");

   a_invalid_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.invalid |-> !rsp_ff.reg_write && !rsp_ff.mem_load
         && !rsp_ff.mem_store && !rsp_ff.redirect && !rsp_ff.overflow)
      else $error("invalid instruction produced side effects");

   a_mem_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.mem_load && rsp_ff.mem_store))
      else $error("load and store flagged together");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !rsp_advance |=> req_valid_ff && $stable(req_data_ff))
      else $error("input register overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/mde_exec.sv =====
`default_nettype none

module mde_exec (
   input  wire logic [31:0]               instruction,
   input  wire logic [31:0]               pc,
   input  wire logic [31:0]               rs_value,
   input  wire logic [31:0]               rt_value,
   output mde_pkg::exec_result_type       exec_out
);

   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sa;
   logic [31:0] simm;
   logic [31:0] zimm;
   logic [31:0] seq_pc;
   logic [31:0] link_pc;
   logic [31:0] sum_ab;
   logic [31:0] diff_ab;
   logic [31:0] sum_imm;
   logic [31:0] branch_target;
   logic [31:0] jump_target;
   logic        ovf_ab;
   logic        ovf_sub;
   logic        ovf_imm;

   assign op            = instruction[31:26];
   assign rt            = instruction[20:16];
   assign rd            = instruction[15:11];
   assign sa            = instruction[10:6];
   assign fn            = instruction[5:0];
   assign simm          = {{16{instruction[15]}}, instruction[15:0]};
   assign zimm          = {16'h0000, instruction[15:0]};
   assign seq_pc        = pc + 32'd4;
   assign link_pc       = pc + 32'd8;
   assign sum_ab        = rs_value + rt_value;
   assign diff_ab       = rs_value - rt_value;
   assign sum_imm       = rs_value + simm;
   assign branch_target = seq_pc + {simm[29:0], 2'b00};
   assign jump_target   = {seq_pc[31:28], instruction[25:0], 2'b00};

   // signed overflow: add operands agree in sign (subtract operands differ), result sign differs from rs
   assign ovf_ab  = (rs_value[31] == rt_value[31]) && (sum_ab[31] != rs_value[31]);
   assign ovf_sub = (rs_value[31] != rt_value[31]) && (diff_ab[31] != rs_value[31]);
   assign ovf_imm = (rs_value[31] == simm[31]) && (sum_imm[31] != rs_value[31]);

   always_comb begin
      exec_out             = '0;
      exec_out.next_pc     = seq_pc;
      case (op)
         mde_pkg::OP_SPECIAL: begin
            exec_out.dest_reg  = rd;
            exec_out.reg_write = 1'b1;
            case (fn)
               mde_pkg::FN_ADD: begin
                  exec_out.result   = sum_ab;
                  exec_out.overflow = ovf_ab;
               end
               mde_pkg::FN_ADDU: exec_out.result = sum_ab;
               mde_pkg::FN_SUB: begin
                  exec_out.result   = diff_ab;
                  exec_out.overflow = ovf_sub;
               end
               mde_pkg::FN_SUBU: exec_out.result = diff_ab;
               mde_pkg::FN_AND:  exec_out.result = rs_value & rt_value;
               mde_pkg::FN_OR:   exec_out.result = rs_value | rt_value;
               mde_pkg::FN_NOR:  exec_out.result = ~(rs_value | rt_value);
               mde_pkg::FN_SLT:
                  exec_out.result = {31'd0, $signed(rs_value) < $signed(rt_value)};
               mde_pkg::FN_SLTU: exec_out.result = {31'd0, rs_value < rt_value};
               mde_pkg::FN_SLL:  exec_out.result = rt_value << sa;
               mde_pkg::FN_SRL:  exec_out.result = rt_value >> sa;
               mde_pkg::FN_JR: begin
                  exec_out.dest_reg  = '0;
                  exec_out.reg_write = 1'b0;
                  exec_out.next_pc   = rs_value;
                  exec_out.redirect  = 1'b1;
               end
               default: begin
                  exec_out.dest_reg  = '0;
                  exec_out.reg_write = 1'b0;
                  exec_out.invalid   = 1'b1;
               end
            endcase
         end
         mde_pkg::OP_J: begin
            exec_out.next_pc  = jump_target;
            exec_out.redirect = 1'b1;
         end
         mde_pkg::OP_JAL: begin
            exec_out.next_pc   = jump_target;
            exec_out.redirect  = 1'b1;
            exec_out.result    = link_pc;
            exec_out.dest_reg  = mde_pkg::LINK_REG;
            exec_out.reg_write = 1'b1;
         end
         mde_pkg::OP_BEQ, mde_pkg::OP_BNE: begin
            if ((op == mde_pkg::OP_BEQ) == (rs_value == rt_value)) begin
               exec_out.next_pc  = branch_target;
               exec_out.redirect = 1'b1;
            end
         end
         mde_pkg::OP_ADDI: begin
            exec_out.result    = sum_imm;
            exec_out.overflow  = ovf_imm;
            exec_out.dest_reg  = rt;
            exec_out.reg_write = 1'b1;
         end
         mde_pkg::OP_ADDIU: begin
            exec_out.result    = sum_imm;
            exec_out.dest_reg  = rt;
            exec_out.reg_write = 1'b1;
         end
         mde_pkg::OP_SLTI: begin
            exec_out.result    = {31'd0, $signed(rs_value) < $signed(simm)};
            exec_out.dest_reg  = rt;
            exec_out.reg_write = 1'b1;
         end
         mde_pkg::OP_SLTIU: begin
            exec_out.result    = {31'd0, rs_value < simm};
            exec_out.dest_reg  = rt;
            exec_out.reg_write = 1'b1;
         end
         mde_pkg::OP_ANDI: begin
            exec_out.result    = rs_value & zimm;
            exec_out.dest_reg  = rt;
            exec_out.reg_write = 1'b1;
         end
         mde_pkg::OP_ORI: begin
            exec_out.result    = rs_value | zimm;
            exec_out.dest_reg  = rt;
            exec_out.reg_write = 1'b1;
         end
         mde_pkg::OP_LUI: begin
            exec_out.result    = {instruction[15:0], 16'h0000};
            exec_out.dest_reg  = rt;
            exec_out.reg_write = 1'b1;
         end
         mde_pkg::OP_LBU, mde_pkg::OP_LHU, mde_pkg::OP_LW, mde_pkg::OP_LL: begin
            exec_out.result    = sum_imm;
            exec_out.dest_reg  = rt;
            exec_out.reg_write = 1'b1;
            exec_out.mem_load  = 1'b1;
            if (op == mde_pkg::OP_LBU) begin
               exec_out.access_size = mde_pkg::SIZE_BYTE;
            end else if (op == mde_pkg::OP_LHU) begin
               exec_out.access_size = mde_pkg::SIZE_HALF;
            end else begin
               exec_out.access_size = mde_pkg::SIZE_WORD;
            end
         end
         mde_pkg::OP_SB, mde_pkg::OP_SH, mde_pkg::OP_SW, mde_pkg::OP_SC: begin
            // sc behaves as a plain word store
            exec_out.result     = sum_imm;
            exec_out.mem_store  = 1'b1;
            exec_out.store_data = rt_value;
            if (op == mde_pkg::OP_SB) begin
               exec_out.access_size = mde_pkg::SIZE_BYTE;
            end else if (op == mde_pkg::OP_SH) begin
               exec_out.access_size = mde_pkg::SIZE_HALF;
            end else begin
               exec_out.access_size = mde_pkg::SIZE_WORD;
            end
         end
         default: begin
            exec_out.invalid = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

// Holds the expected execute results of accepted requests and checks responses in order.
class exec_board;
   mde_pkg::exec_result_type expected_q[$];
   logic [31:0] instr_q[$];
   int mismatches;
   int checked;
   int redirects;
   int overflows;
   int invalids;
   int mem_ops;

   function bit add_overflow(logic [31:0] a, logic [31:0] b, logic [31:0] sum);
      return (a[31] == b[31]) && (sum[31] != a[31]);
   endfunction

   function mde_pkg::exec_result_type predict_exec(logic [31:0] instr, logic [31:0] pc,
                                                  logic [31:0] a, logic [31:0] b);
      mde_pkg::exec_result_type r;
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rt_f;
      logic [4:0]  rd_f;
      logic [4:0]  sa;
      logic [31:0] simm;
      logic [31:0] zimm;
      logic [31:0] seq;
      op = instr[31:26];
      fn = instr[5:0];
      rt_f = instr[20:16];
      rd_f = instr[15:11];
      sa = instr[10:6];
      simm = {{16{instr[15]}}, instr[15:0]};
      zimm = {16'h0000, instr[15:0]};
      seq = pc + 32'd4;
      r = '0;
      r.next_pc = seq;
      case (op)
         mde_pkg::OP_SPECIAL: begin
            r.dest_reg = rd_f;
            r.reg_write = 1'b1;
            case (fn)
               mde_pkg::FN_ADD: begin
                  r.result = a + b;
                  r.overflow = add_overflow(a, b, r.result);
               end
               mde_pkg::FN_ADDU: r.result = a + b;
               mde_pkg::FN_SUB: begin
                  r.result = a - b;
                  r.overflow = (a[31] != b[31]) && (r.result[31] != a[31]);
               end
               mde_pkg::FN_SUBU: r.result = a - b;
               mde_pkg::FN_AND:  r.result = a & b;
               mde_pkg::FN_OR:   r.result = a | b;
               mde_pkg::FN_NOR:  r.result = ~(a | b);
               mde_pkg::FN_SLT:  r.result = {31'd0, $signed(a) < $signed(b)};
               mde_pkg::FN_SLTU: r.result = {31'd0, a < b};
               mde_pkg::FN_SLL:  r.result = b << sa;
               mde_pkg::FN_SRL:  r.result = b >> sa;
               mde_pkg::FN_JR: begin
                  r.dest_reg = '0;
                  r.reg_write = 1'b0;
                  r.next_pc = a;
                  r.redirect = 1'b1;
               end
               default: begin
                  r.dest_reg = '0;
                  r.reg_write = 1'b0;
                  r.invalid = 1'b1;
               end
            endcase
         end
         mde_pkg::OP_J, mde_pkg::OP_JAL: begin
            // region bits come from the sequential pc, not this one
            r.next_pc = {seq[31:28], instr[25:0], 2'b00};
            r.redirect = 1'b1;
            if (op == mde_pkg::OP_JAL) begin
               r.result = pc + 32'd8;
               r.dest_reg = mde_pkg::LINK_REG;
               r.reg_write = 1'b1;
            end
         end
         mde_pkg::OP_BEQ, mde_pkg::OP_BNE: begin
            if ((op == mde_pkg::OP_BEQ) == (a == b)) begin
               r.next_pc = seq + {simm[29:0], 2'b00};
               r.redirect = 1'b1;
            end
         end
         mde_pkg::OP_ADDI: begin
            r.result = a + simm;
            r.overflow = add_overflow(a, simm, r.result);
            r.dest_reg = rt_f;
            r.reg_write = 1'b1;
         end
         mde_pkg::OP_ADDIU, mde_pkg::OP_SLTI, mde_pkg::OP_SLTIU, mde_pkg::OP_ANDI,
         mde_pkg::OP_ORI, mde_pkg::OP_LUI: begin
            r.dest_reg = rt_f;
            r.reg_write = 1'b1;
            case (op)
               mde_pkg::OP_ADDIU: r.result = a + simm;
               mde_pkg::OP_SLTI:  r.result = {31'd0, $signed(a) < $signed(simm)};
               mde_pkg::OP_SLTIU: r.result = {31'd0, a < simm};
               mde_pkg::OP_ANDI:  r.result = a & zimm;
               mde_pkg::OP_ORI:   r.result = a | zimm;
               default:           r.result = {instr[15:0], 16'h0000};
            endcase
         end
         mde_pkg::OP_LBU, mde_pkg::OP_LHU, mde_pkg::OP_LW, mde_pkg::OP_LL: begin
            r.result = a + simm;
            r.dest_reg = rt_f;
            r.reg_write = 1'b1;
            r.mem_load = 1'b1;
            r.access_size = (op == mde_pkg::OP_LBU) ? mde_pkg::SIZE_BYTE :
                            (op == mde_pkg::OP_LHU) ? mde_pkg::SIZE_HALF : mde_pkg::SIZE_WORD;
         end
         mde_pkg::OP_SB, mde_pkg::OP_SH, mde_pkg::OP_SW, mde_pkg::OP_SC: begin
            r.result = a + simm;
            r.mem_store = 1'b1;
            r.store_data = b;
            r.access_size = (op == mde_pkg::OP_SB) ? mde_pkg::SIZE_BYTE :
                            (op == mde_pkg::OP_SH) ? mde_pkg::SIZE_HALF : mde_pkg::SIZE_WORD;
         end
         default: r.invalid = 1'b1;
      endcase
      return r;
   endfunction

   function void note_request(logic [31:0] instr, logic [31:0] pc,
                              logic [31:0] a, logic [31:0] b);
      mde_pkg::exec_result_type exp;
      exp = predict_exec(instr, pc, a, b);
      expected_q.push_back(exp);
      instr_q.push_back(instr);
      redirects += exp.redirect;
      overflows += exp.overflow;
      invalids += exp.invalid;
      mem_ops += exp.mem_load | exp.mem_store;
   endfunction

   function void check_response(logic [111:0] d);
      mde_pkg::exec_result_type got;
      mde_pkg::exec_result_type exp;
      logic [31:0] instr;
      string bad;
      got.result = d[31:0];
      got.dest_reg = d[36:32];
      got.reg_write = d[37];
      got.mem_load = d[38];
      got.mem_store = d[39];
      got.access_size = d[41:40];
      got.store_data = d[73:42];
      got.next_pc = d[105:74];
      got.redirect = d[106];
      got.overflow = d[107];
      got.invalid = d[108];
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response with no request outstanding: %h", d);
         return;
      end
      exp = expected_q.pop_front();
      instr = instr_q.pop_front();
      checked++;
      bad = "";
      if (got.result !== exp.result)           bad = {bad, " result"};
      if (got.dest_reg !== exp.dest_reg)       bad = {bad, " dest_reg"};
      if (got.reg_write !== exp.reg_write)     bad = {bad, " reg_write"};
      if (got.mem_load !== exp.mem_load)       bad = {bad, " mem_load"};
      if (got.mem_store !== exp.mem_store)     bad = {bad, " mem_store"};
      if (got.access_size !== exp.access_size) bad = {bad, " access_size"};
      if (got.store_data !== exp.store_data)   bad = {bad, " store_data"};
      if (got.next_pc !== exp.next_pc)         bad = {bad, " next_pc"};
      if (got.redirect !== exp.redirect)       bad = {bad, " redirect"};
      if (got.overflow !== exp.overflow)       bad = {bad, " overflow"};
      if (got.invalid !== exp.invalid)         bad = {bad, " invalid"};
      if (bad != "") begin
         mismatches++;
         if (mismatches <= 10)
            $display("instr %h mismatch in%s: expected %h got %h", instr, bad, exp, got);
      end
   endfunction
endclass

module tb;

   localparam logic [5:0] FN_UNUSED = 6'h3f;
   localparam logic [5:0] OP_UNUSED = 6'h3f;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   exec_board board;

   mips_decode_execute u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [31:0] r_word(mde_pkg::funct_type fn, logic [4:0] rd,
                                          logic [4:0] sa);
      return {mde_pkg::OP_SPECIAL, 5'd1, 5'd2, rd, sa, fn};
   endfunction

   function automatic logic [31:0] i_word(mde_pkg::opcode_type op, logic [4:0] rt,
                                          logic [15:0] imm);
      return {op, 5'd3, rt, imm};
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h7fff_ffff;
         3:       return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(input logic [31:0] instr, input logic [31:0] pc,
                            input logic [31:0] a, input logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, a, pc, instr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(instr, pc, a, b);
   endtask

   task automatic random_item();
      logic [31:0] instr;
      logic [31:0] pc;
      logic [31:0] a;
      logic [31:0] b;
      mde_pkg::opcode_type op;
      mde_pkg::funct_type  fn;
      instr = $urandom();
      pc = pick_value();
      a = pick_value();
      b = pick_value();
      // mostly legal opcodes with random fields; the rest is raw noise
      if ($urandom_range(99) < 85) begin
         op = op.first();
         repeat ($urandom_range(op.num() - 1)) op = op.next();
         instr[31:26] = op;
         if (op == mde_pkg::OP_SPECIAL && $urandom_range(9) != 0) begin
            fn = fn.first();
            repeat ($urandom_range(fn.num() - 1)) fn = fn.next();
            instr[5:0] = fn;
         end
      end
      if ((instr[31:26] == mde_pkg::OP_BEQ || instr[31:26] == mde_pkg::OP_BNE)
          && $urandom_range(1) == 1)
         b = a;
      send_item(instr, pc, a, b);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      mde_pkg::opcode_type op;
      board = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // arithmetic corners, shifts, compares, jr, bad codes
      send_item(r_word(mde_pkg::FN_ADD, 5'd5, 5'd0), 32'h0000_1000, 32'h7fff_ffff,
                32'h0000_0001);
      send_item(r_word(mde_pkg::FN_SUB, 5'd0, 5'd0), 32'h0000_1004, 32'h8000_0000,
                32'h0000_0001);
      send_item(r_word(mde_pkg::FN_ADDU, 5'd6, 5'd0), 32'h0, 32'hffff_ffff, 32'h0000_0001);
      send_item(r_word(mde_pkg::FN_SUBU, 5'd7, 5'd0), 32'h0, 32'h0000_0000, 32'h0000_0001);
      send_item(r_word(mde_pkg::FN_AND, 5'd8, 5'd0), 32'h0, 32'hffff_ffff, 32'h0f0f_0f0f);
      send_item(r_word(mde_pkg::FN_OR, 5'd9, 5'd0), 32'h0, 32'h8000_0000, 32'h0000_0001);
      send_item(r_word(mde_pkg::FN_NOR, 5'd10, 5'd0), 32'h0, 32'h0000_0000, 32'h0000_0000);
      send_item(r_word(mde_pkg::FN_SLT, 5'd11, 5'd0), 32'h0, 32'h8000_0000, 32'h0000_0001);
      send_item(r_word(mde_pkg::FN_SLTU, 5'd12, 5'd0), 32'h0, 32'h8000_0000, 32'h0000_0001);
      send_item(r_word(mde_pkg::FN_SLL, 5'd13, 5'd31), 32'h0, 32'h0, 32'h0000_0001);
      send_item(r_word(mde_pkg::FN_SRL, 5'd31, 5'd31), 32'h0, 32'h0, 32'h8000_0000);
      send_item(r_word(mde_pkg::FN_JR, 5'd0, 5'd0), 32'h0000_2000, 32'h1234_5678, 32'h0);
      send_item({mde_pkg::OP_SPECIAL, 20'hfffff, FN_UNUSED}, 32'hffff_fffc, 32'hffff_ffff,
                32'hffff_ffff);
      send_item({OP_UNUSED, 26'h3ff_ffff}, 32'hffff_fffc, 32'hffff_ffff, 32'hffff_ffff);
      // jumps across the region boundary and at the top of memory
      send_item({mde_pkg::OP_J, 26'h3ff_ffff}, 32'hffff_fffc, 32'h0, 32'h0);
      send_item({mde_pkg::OP_JAL, 26'h000_0001}, 32'h7fff_fffc, 32'h0, 32'h0);
      send_item(i_word(mde_pkg::OP_BEQ, 5'd4, 16'h8000), 32'h0000_0000, 32'h5555_5555,
                32'h5555_5555);
      send_item(i_word(mde_pkg::OP_BNE, 5'd4, 16'h7fff), 32'hffff_0000, 32'h0000_0001,
                32'h0000_0002);
      send_item(i_word(mde_pkg::OP_BNE, 5'd4, 16'h0010), 32'h0000_0100, 32'h0000_0003,
                32'h0000_0003);
      send_item(i_word(mde_pkg::OP_ADDI, 5'd1, 16'h0001), 32'h0, 32'h7fff_ffff, 32'h0);
      send_item(i_word(mde_pkg::OP_ADDIU, 5'd2, 16'hffff), 32'h0, 32'h0000_0000, 32'h0);
      send_item(i_word(mde_pkg::OP_SLTI, 5'd3, 16'hffff), 32'h0, 32'h8000_0000, 32'h0);
      send_item(i_word(mde_pkg::OP_SLTIU, 5'd4, 16'hffff), 32'h0, 32'hffff_fffe, 32'h0);
      send_item(i_word(mde_pkg::OP_ANDI, 5'd5, 16'hffff), 32'h0, 32'hffff_ffff, 32'h0);
      send_item(i_word(mde_pkg::OP_ORI, 5'd6, 16'h8000), 32'h0, 32'h0000_0000, 32'h0);
      send_item(i_word(mde_pkg::OP_LUI, 5'd7, 16'hffff), 32'h0, 32'h0, 32'h0);
      // every load and store, destination zero included
      op = op.first();
      repeat (op.num()) begin
         if (op >= mde_pkg::OP_LW)
            send_item(i_word(op, 5'd0, 16'h8000), 32'h0, 32'h0000_0004, 32'hdead_beef);
         op = op.next();
      end
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 57 : (phase == 3) ? 19 : 0;
         recv_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 19 : 0;
         repeat (450) random_item();
         // hold requests until the pipe is empty
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("Checked %0d instructions in directed and four flow-control phases:",
               board.checked);
      $display("%0d redirects, %0d overflows, %0d invalid, %0d memory accesses",
               board.redirects, board.overflows, board.invalids, board.mem_ops);
      if (board.mismatches == 0 && board.expected_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

`default_nettype wire
